// ----- rtl/hrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types and constants of the hex record flash word packer.
// ----------------------------------------------------------------------------
package hrfp_pkg;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_SEG  = 8'h02;
    localparam logic [7:0] REC_EXT  = 8'h04;

    localparam logic [7:0] IDX_BASE_HI = 8'd0;
    localparam logic [7:0] IDX_BASE_LO = 8'd1;

    localparam logic [1:0] LANE_0    = 2'd0;
    localparam logic [1:0] LANE_1    = 2'd1;
    localparam logic [1:0] LANE_2    = 2'd2;
    localparam logic [1:0] LANE_FULL = 2'd3;

    localparam logic [23:0] FILL_LANE_0 = 24'hFF_FFFF;
    localparam logic [23:0] FILL_LANE_1 = 24'h00_FFFF;
    localparam logic [23:0] FILL_LANE_2 = 24'h00_00FF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] base;
        logic [15:0] offset;
        logic [7:0]  index;
        logic [7:0]  value;
        logic        last;
    } cmd_t;

endpackage

// ----- rtl/hrfp_front.sv -----
// ----------------------------------------------------------------------------
// hrfp_front
// Accepts record bytes, loads the segment and extended bases and forwards
// data bytes with the current base sum as commands.
// ----------------------------------------------------------------------------
module hrfp_front import hrfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic [7:0]  rec_type,
    input  logic [15:0] rec_offset,
    input  logic [7:0]  byte_index,
    input  logic [7:0]  byte_value,
    input  logic        last_in_record,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [15:0] ext_reg, ext_next;
    logic [15:0] seg_reg, seg_next;
    logic [7:0]  pend_reg, pend_next;
    logic [31:0] base_reg, base_next;
    logic        is_base;

    assign is_base = (rec_type == REC_SEG) || (rec_type == REC_EXT);

    always_comb begin
        ext_next  = ext_reg;
        seg_next  = seg_reg;
        pend_next = pend_reg;
        if (in_accept && is_base) begin
            if (byte_index == IDX_BASE_HI) begin
                pend_next = byte_value;
            end else if (byte_index == IDX_BASE_LO) begin
                if (rec_type == REC_EXT) begin
                    ext_next = {pend_reg, byte_value};
                end else begin
                    seg_next = {pend_reg, byte_value};
                end
            end
        end
        base_next = {ext_next, 16'h0000} + {12'h000, seg_next, 4'h0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg  <= '0;
            seg_reg  <= '0;
            pend_reg <= '0;
            base_reg <= '0;
        end else begin
            ext_reg  <= ext_next;
            seg_reg  <= seg_next;
            pend_reg <= pend_next;
            base_reg <= base_next;
        end
    end

    assign push            = in_accept && (rec_type == REC_DATA);
    assign push_cmd.base   = base_reg;
    assign push_cmd.offset = rec_offset;
    assign push_cmd.index  = byte_index;
    assign push_cmd.value  = byte_value;
    assign push_cmd.last   = last_in_record;

endmodule

// ----- rtl/hrfp_queue.sv -----
// ----------------------------------------------------------------------------
// hrfp_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module hrfp_queue import hrfp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hrfp_back.sv -----
// ----------------------------------------------------------------------------
// hrfp_back
// Packs data bytes into flash words, forms the word address and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module hrfp_back import hrfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_address,
    output logic [31:0] out_word,
    output logic        out_padded
);

    logic [23:0] acc_reg, acc_next;
    logic        valid_reg;
    logic [31:0] addr_reg;
    logic [31:0] word_reg;
    logic        pad_reg;
    logic [31:0] addr_calc;
    logic [31:0] word_calc;
    logic [23:0] fill;
    logic        emit;
    logic        pad_calc;
    logic [1:0]  lane;

    assign lane      = q_head.index[1:0];
    assign q_pop     = !q_empty && (!valid_reg || out_ready);
    assign addr_calc = q_head.base + {16'h0000, q_head.offset}
                     + {24'h000000, q_head.index[7:2], 2'b00};

    always_comb begin
        acc_next  = acc_reg;
        fill      = '0;
        emit      = q_head.last;
        pad_calc  = 1'b1;
        case (lane)
            LANE_0: begin
                acc_next = {q_head.value, 16'h0000};
                fill     = FILL_LANE_0;
            end
            LANE_1: begin
                acc_next = {acc_reg[23:16], q_head.value, 8'h00};
                fill     = FILL_LANE_1;
            end
            LANE_2: begin
                acc_next = {acc_reg[23:8], q_head.value};
                fill     = FILL_LANE_2;
            end
            default: begin
                emit     = 1'b1;
                pad_calc = 1'b0;
            end
        endcase
        if (lane == LANE_FULL) begin
            word_calc = {acc_reg, q_head.value};
        end else begin
            word_calc = {acc_next, 8'h00} | {8'h00, fill};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                acc_reg   <= acc_next;
                valid_reg <= emit;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            addr_reg <= addr_calc;
            word_reg <= word_calc;
            pad_reg  <= pad_calc;
        end
    end

    assign out_valid   = valid_reg;
    assign out_address = addr_reg;
    assign out_word    = word_reg;
    assign out_padded  = pad_reg;

endmodule

// ----- rtl/hex_record_flash_word_packer_unit.sv -----
// ----------------------------------------------------------------------------
// hex_record_flash_word_packer_unit
// Packs parsed hex record data bytes into addressed 32-bit flash words.
// ----------------------------------------------------------------------------
// Input stream: one record byte per transfer. s_tuser carries the record
// type, s_tlast marks the record's last data byte, s_tdata the offset, the
// byte index and the byte. Segment and extended base records are absorbed
// by the front part at once; data bytes enter a four-entry command queue.
// Output stream: one transfer per completed or padded word, m_tdata holding
// the byte address and the word, m_tuser[0] set when low bytes were padded.
// Throughput: one byte per cycle, sustained while m_tready stays high. A
// word appears on m_tvalid once the byte that completes it has passed the
// queue and the output register of the packing stage.
// When m_tready is low the output register holds its word; the queue then
// takes up to four more data bytes before s_tready drops.
// Reset (aresetn low, synchronous) clears both bases, the pending base byte,
// the packing accumulator and the queue.
// ----------------------------------------------------------------------------
module hex_record_flash_word_packer_unit import hrfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rec_offset[15:0], byte_index[23:16], byte_value[31:24]
    input  logic [7:0]  s_tuser,   // rec_type[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // flash_address[31:0], flash_word[63:32]
    output logic [7:0]  m_tuser    // padded[0], zero[7:1]
);

    logic        in_accept;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    cmd_t        q_head;
    logic [31:0] out_address;
    logic [31:0] out_word;
    logic        out_padded;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    hrfp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .rec_type       (s_tuser),
        .rec_offset     (s_tdata[15:0]),
        .byte_index     (s_tdata[23:16]),
        .byte_value     (s_tdata[31:24]),
        .last_in_record (s_tlast),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    hrfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    hrfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (out_address),
        .out_word    (out_word),
        .out_padded  (out_padded)
    );

    assign m_tdata = {out_word, out_address};
    assign m_tuser = {7'b0000000, out_padded};

endmodule
